// ===== rtl/chtu_pkg.sv =====
`timescale 1ns / 1ps
package chtu_pkg;
   localparam int BUCKETS = 256;
   localparam int NODES = 1024;
   localparam int NODE_W = $clog2(NODES);
   localparam int LINK_W = NODE_W + 1;
   localparam int BKT_W = $clog2(BUCKETS);
   localparam int BCNT_W = 9;
   localparam int LIMIT_W = 11;
   localparam int KEY_W = 64;
   localparam int DIGITS = 4;
   localparam int DIV_STEPS = KEY_W / DIGITS;

   // Top bit of a link marks the end of a chain.
   localparam logic [LINK_W-1:0] LINK_NULL = {1'b1, {NODE_W{1'b0}}};

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_ERASE = 2'd1;
   localparam logic [1:0] MODE_FIND = 2'd2;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_REPLACED = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_ERASED = 3'd3;
   localparam logic [2:0] ST_MISSING = 3'd4;
   localparam logic [2:0] ST_FOUND = 3'd5;

   localparam logic REG_BUCKETS = 1'b0;
   localparam logic REG_NODE_LIMIT = 1'b1;
endpackage

// ===== rtl/chtu_mod.sv =====
`timescale 1ns / 1ps
module chtu_mod (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [chtu_pkg::KEY_W-1:0]      dividend,
   input  logic [chtu_pkg::BCNT_W-1:0]     divisor,
   output logic                            done,
   output logic [chtu_pkg::BKT_W-1:0]      remainder
);
   import chtu_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic [KEY_W-1:0]  sh_ff, sh_in;
   logic [BCNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [BCNT_W:0]   trial;
   logic [BCNT_W-1:0] step_rem;

   // Restoring remainder, several dividend bits per cycle.
   always_comb begin
      step_rem = rem_ff;
      trial = '0;
      for (int i = 0; i < DIGITS; i++) begin
         trial = {step_rem, sh_ff[KEY_W-1-i]};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         step_rem = trial[BCNT_W-1:0];
      end
   end

   always_comb begin
      sh_in = sh_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         sh_in = dividend;
         rem_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in = sh_ff << DIGITS;
         rem_in = step_rem;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign remainder = rem_ff[BKT_W-1:0];
endmodule

// ===== rtl/chained_hash_table_unit.sv =====
`timescale 1ns / 1ps
// Chained hash table: keyed store of 64-bit values, separate chaining over a
// pool of 1024 nodes in 256 buckets.
// Request channel req_*: mode, key, value. One response per request on rsp_*:
// status, found_value, entry_count. Both channels move a transaction when
// valid is high and stall is low.
// Registers on the csr_ port: number of buckets in use at 0x0, node limit at
// 0x4. Write them only while no request is in flight.
// The bucket is the key modulo the bucket register (read as 1 when 0 and as
// 256 when above 256), computed 4 bits a cycle; the bucket head is then read,
// each chain node costs one node memory read and one key compare, and an
// insert or erase that relinks the chain adds a link state before the
// response. One request is handled at a time; the next one is taken the
// cycle after the response is registered.
// The response sits in an output register: a stalled response holds while the
// next request is already taken and worked on; that request waits only at
// its own output.
// Reset empties the table (bucket valid bits clear at once, the free pool
// restarts) and loads 256 buckets and a node limit of 1024. No clearing pass.
module chained_hash_table_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic [chtu_pkg::KEY_W-1:0]      req_key,
   input  logic [chtu_pkg::KEY_W-1:0]      req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_status,
   output logic [chtu_pkg::KEY_W-1:0]      rsp_found_value,
   output logic [chtu_pkg::LIMIT_W-1:0]    rsp_entry_count,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [2:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import chtu_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MOD, S_HEAD, S_HEADCHK, S_NODE, S_CMP, S_UPD, S_LINK, S_OUT
   } state_type;

   state_type state_ff;

   logic [BCNT_W-1:0]  bcount_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [BCNT_W-1:0]  eff_buckets;
   logic [LIMIT_W-1:0] eff_limit;

   logic [1:0]         mode_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   val_ff;
   logic [BKT_W-1:0]   bucket_ff;
   logic [LINK_W-1:0]  cur_ff;
   logic [LINK_W-1:0]  prev_ff;
   logic [NODE_W-1:0]  node_ff;
   logic               hit_ff;
   logic [LIMIT_W-1:0] live_ff;
   logic [LIMIT_W-1:0] rec_ff;
   logic [LIMIT_W-1:0] fresh_ff;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [KEY_W-1:0]   rsp_value_ff;
   logic [LIMIT_W-1:0] rsp_count_ff;
   logic [2:0]         status_ff;
   logic [KEY_W-1:0]   result_ff;

   logic [LINK_W-1:0]  head_mem [BUCKETS];
   logic [BUCKETS-1:0] head_vld_ff;
   logic [KEY_W-1:0]   key_mem [NODES];
   logic [KEY_W-1:0]   val_mem [NODES];
   logic [LINK_W-1:0]  next_mem [NODES];
   logic [NODE_W-1:0]  fl_mem [NODES];

   logic [LINK_W-1:0]  head_rd_ff;
   logic               head_vld_rd_ff;
   logic [KEY_W-1:0]   key_rd_ff;
   logic [KEY_W-1:0]   val_rd_ff;
   logic [LINK_W-1:0]  next_rd_ff;
   logic [NODE_W-1:0]  fl_rd_ff;

   logic               req_accept;
   logic               csr_write;
   logic               mod_done;
   logic [BKT_W-1:0]   mod_rem;
   logic               out_free;
   logic [LINK_W-1:0]  head_link;
   logic [NODE_W-1:0]  new_node;
   logic [LINK_W-1:0]  link_val;
   logic               full;

   logic               key_we, val_we, next_we, head_we, fl_we;
   logic [NODE_W-1:0]  val_waddr, next_waddr;
   logic [KEY_W-1:0]   val_wdata;
   logic [LINK_W-1:0]  next_wdata;

   assign req_accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (csr_paddr[2])
         REG_BUCKETS:    csr_prdata = 32'(bcount_ff);
         REG_NODE_LIMIT: csr_prdata = 32'(limit_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (bcount_ff == '0) begin
         eff_buckets = BCNT_W'(1);
      end else if (bcount_ff > BCNT_W'(BUCKETS)) begin
         eff_buckets = BCNT_W'(BUCKETS);
      end else begin
         eff_buckets = bcount_ff;
      end
      if (limit_ff > LIMIT_W'(NODES)) begin
         eff_limit = LIMIT_W'(NODES);
      end else begin
         eff_limit = limit_ff;
      end
   end

   chtu_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .dividend  (req_key),
      .divisor   (eff_buckets),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign head_link = head_vld_rd_ff ? head_rd_ff : LINK_NULL;
   assign new_node = (rec_ff != '0) ? fl_rd_ff : fresh_ff[NODE_W-1:0];
   assign full = (live_ff >= eff_limit);
   assign link_val = (mode_ff == MODE_ERASE) ? next_rd_ff : {1'b0, node_ff};

   // Write ports of the node, bucket head and free-list memories.
   always_comb begin
      key_we = 1'b0;
      val_we = 1'b0;
      next_we = 1'b0;
      head_we = 1'b0;
      fl_we = 1'b0;
      val_waddr = cur_ff[NODE_W-1:0];
      val_wdata = val_ff;
      next_waddr = new_node;
      next_wdata = LINK_NULL;
      if (state_ff == S_UPD) begin
         case (mode_ff)
            MODE_INSERT: begin
               if (hit_ff) begin
                  val_we = 1'b1;
               end else if (!full) begin
                  key_we = 1'b1;
                  val_we = 1'b1;
                  next_we = 1'b1;
                  val_waddr = new_node;
               end
            end
            MODE_ERASE: fl_we = hit_ff;
            default: ;
         endcase
      end else if (state_ff == S_LINK) begin
         if (prev_ff[LINK_W-1]) begin
            head_we = 1'b1;
         end else begin
            next_we = 1'b1;
            next_waddr = prev_ff[NODE_W-1:0];
            next_wdata = link_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[new_node] <= key_ff;
      if (val_we) val_mem[val_waddr] <= val_wdata;
      if (next_we) next_mem[next_waddr] <= next_wdata;
      if (head_we) head_mem[bucket_ff] <= link_val;
      if (fl_we) fl_mem[rec_ff[NODE_W-1:0]] <= cur_ff[NODE_W-1:0];
      head_rd_ff <= head_mem[bucket_ff];
      key_rd_ff <= key_mem[cur_ff[NODE_W-1:0]];
      val_rd_ff <= val_mem[cur_ff[NODE_W-1:0]];
      next_rd_ff <= next_mem[cur_ff[NODE_W-1:0]];
      fl_rd_ff <= fl_mem[rec_ff[NODE_W-1:0] - 1'b1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
         head_vld_rd_ff <= 1'b0;
      end else begin
         if (head_we) head_vld_ff[bucket_ff] <= 1'b1;
         head_vld_rd_ff <= head_vld_ff[bucket_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcount_ff <= BCNT_W'(BUCKETS);
         limit_ff <= LIMIT_W'(NODES);
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_BUCKETS:    bcount_ff <= csr_pwdata[BCNT_W-1:0];
            REG_NODE_LIMIT: limit_ff <= csr_pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff <= req_mode;
         key_ff <= req_key;
         val_ff <= req_value;
      end
      if (reset) begin
         state_ff <= S_IDLE;
         live_ff <= '0;
         rec_ff <= '0;
         fresh_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_accept) state_ff <= S_MOD;
            S_MOD: begin
               if (mod_done) begin
                  bucket_ff <= mod_rem;
                  state_ff <= S_HEAD;
               end
            end
            S_HEAD: state_ff <= S_HEADCHK;
            S_HEADCHK: begin
               prev_ff <= LINK_NULL;
               cur_ff <= head_link;
               hit_ff <= 1'b0;
               state_ff <= head_link[LINK_W-1] ? S_UPD : S_NODE;
            end
            S_NODE: state_ff <= S_CMP;
            S_CMP: begin
               if (key_rd_ff == key_ff) begin
                  hit_ff <= 1'b1;
                  state_ff <= S_UPD;
               end else begin
                  prev_ff <= cur_ff;
                  cur_ff <= next_rd_ff;
                  state_ff <= next_rd_ff[LINK_W-1] ? S_UPD : S_NODE;
               end
            end
            S_UPD: begin
               case (mode_ff)
                  MODE_INSERT: begin
                     result_ff <= '0;
                     if (hit_ff) begin
                        status_ff <= ST_REPLACED;
                        state_ff <= S_OUT;
                     end else if (full) begin
                        status_ff <= ST_FULL;
                        state_ff <= S_OUT;
                     end else begin
                        status_ff <= ST_INSERTED;
                        node_ff <= new_node;
                        if (rec_ff != '0) begin
                           rec_ff <= rec_ff - 1'b1;
                        end else begin
                           fresh_ff <= fresh_ff + 1'b1;
                        end
                        live_ff <= live_ff + 1'b1;
                        state_ff <= S_LINK;
                     end
                  end
                  MODE_ERASE: begin
                     result_ff <= '0;
                     if (hit_ff) begin
                        status_ff <= ST_ERASED;
                        rec_ff <= rec_ff + 1'b1;
                        live_ff <= live_ff - 1'b1;
                        state_ff <= S_LINK;
                     end else begin
                        status_ff <= ST_MISSING;
                        state_ff <= S_OUT;
                     end
                  end
                  MODE_FIND: begin
                     state_ff <= S_OUT;
                     if (hit_ff) begin
                        status_ff <= ST_FOUND;
                        result_ff <= val_rd_ff;
                     end else begin
                        status_ff <= ST_MISSING;
                        result_ff <= '0;
                     end
                  end
                  default: begin
                     status_ff <= ST_MISSING;
                     result_ff <= '0;
                     state_ff <= S_OUT;
                  end
               endcase
            end
            S_LINK: state_ff <= S_OUT;
            S_OUT: begin
               // Hold until the output register is free.
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_value_ff <= result_ff;
                  rsp_count_ff <= live_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_pool_balance: assert property (@(posedge clock) disable iff (reset)
      live_ff == fresh_ff - rec_ff)
      else $error("node pool accounting broken");

   a_cmp_on_node: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> !cur_ff[LINK_W-1])
      else $error("key compare on end of chain");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= LIMIT_W'(NODES))
      else $error("live count above pool size");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_MOD)
      else $error("accepted request not started");
endmodule
